[sv/voice_band_level_meter_defines.svh]
// ----------------------------------------------------------------------------
// voice band level meter assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef VOICE_BAND_LEVEL_METER_DEFINES_SVH
`define VOICE_BAND_LEVEL_METER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define VBLM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vblm check failed");

// next-cycle implication, quiet during reset
`define VBLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vblm check failed");

`endif

[sv/vblm_pkg.sv]
// ----------------------------------------------------------------------------
// vblm_pkg
// shared widths, constants, types and helpers of the voice band level meter
// ----------------------------------------------------------------------------
package vblm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 8;
  localparam int SAT_BITS    = SAMPLE_BITS + FRAC_BITS + 4;
  localparam int WARMUP      = 64;
  localparam int DECIMATE    = 4;
  localparam int BIAS_SHIFT  = 4;
  localparam int MEAN_SHIFT  = 5;

  localparam int DEC_LOG  = $clog2(DECIMATE);
  localparam int PHASE_W  = $clog2(DECIMATE + 1);
  localparam int PSUM_W   = SAT_BITS + DEC_LOG + 1;
  localparam int PITCH_SH = DEC_LOG + FRAC_BITS;

  localparam int COEF_W  = 15;
  localparam int OPA_W   = SAT_BITS + 2;
  localparam int PROD_W  = OPA_W + COEF_W + 1;
  localparam int SUM_W   = PROD_W - COEF_W + 1;

  localparam int LVL_W     = 10;
  localparam int SW_W      = 12;
  localparam int CNT_W     = 16;
  localparam int ACC_W     = 16;
  localparam int PITCH_W   = 16;
  localparam int NUM_W     = SW_W + LVL_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  localparam logic [SW_W-1:0]  SW_MAX  = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_FS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_BAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HP_COEF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_COEF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_COEF  = 3'd5;

  localparam logic [LVL_W-1:0]  RST_FULL_SCALE = 10'd180;
  localparam logic [SW_W-1:0]   RST_SWING_FS   = 12'd1024;
  localparam logic              RST_USE_BAND   = 1'b1;
  localparam logic [COEF_W-1:0] RST_HP_COEF    = 15'd29314;
  localparam logic [COEF_W-1:0] RST_LP_COEF    = 15'd17724;
  localparam logic [COEF_W-1:0] RST_PITCH_COEF = 15'd8559;

  typedef logic signed [SAT_BITS-1:0] fix_t;

  typedef enum logic [2:0] {
    OP_HP1,
    OP_PS1,
    OP_PS2,
    OP_HP2,
    OP_BAND
  } mul_op_e;

  typedef struct packed {
    logic [LVL_W-1:0]  full_scale;
    logic [SW_W-1:0]   swing_fs;
    logic              use_band;
    logic [COEF_W-1:0] hp_coef;
    logic [COEF_W-1:0] lp_coef;
    logic [COEF_W-1:0] pitch_coef;
  } cfg_t;

  typedef struct packed {
    logic    accept;
    logic    mul_en;
    logic    wb_en;
    mul_op_e op;
    logic    ld_pitch;
    logic    lvl_mul;
    logic    div_start;
    logic    ld_win;
  } cmd_t;

  typedef struct packed {
    logic pitch_emit;
    logic wend;
    logic div_done;
  } sts_t;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-SAT_BITS+1){1'b0}}, {(SAT_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-SAT_BITS+1){1'b1}}, {(SAT_BITS-1){1'b0}}};

  function automatic fix_t sat_fix(input logic signed [SUM_W-1:0] v);
    fix_t r;
    if (v > SAT_HI) r = SAT_HI[SAT_BITS-1:0];
    else if (v < SAT_LO) r = SAT_LO[SAT_BITS-1:0];
    else r = v[SAT_BITS-1:0];
    return r;
  endfunction

endpackage

[sv/voice_band_level_meter.sv]
// ----------------------------------------------------------------------------
// voice band level meter
// a new sample is accepted only in idle, after the previous one has run the filter chain
// a pitch word is loaded after the PS2 write-back; a window-end word then adds the
// level product, divider start and 22-step divider before the summary word is loaded
// reset is asynchronous active low; filter and window state clear, config to defaults
// ----------------------------------------------------------------------------
`include "voice_band_level_meter_defines.svh"

module voice_band_level_meter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [vblm_pkg::SAMPLE_BITS-1:0]     sample_i,
  input  logic                                 window_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 kind_o,
  output logic signed [vblm_pkg::PITCH_W-1:0]  pitch_sample_o,
  output logic [vblm_pkg::LVL_W-1:0]           level_o,
  output logic [vblm_pkg::LVL_W-1:0]           average_o,
  output logic [vblm_pkg::SW_W-1:0]            bias_o,
  output logic [vblm_pkg::SW_W-1:0]            swing_o,
  output logic [vblm_pkg::SW_W-1:0]            raw_swing_o,
  output logic [vblm_pkg::CNT_W-1:0]           window_count_o,
  output logic                                 last_o,
  input  logic                                 cfg_we_i,
  input  logic [vblm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [vblm_pkg::CFG_DAT_W-1:0]       cfg_data_i
);

  vblm_pkg::cfg_t cfg_q;
  vblm_pkg::cmd_t cmd;
  vblm_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_scale <= vblm_pkg::RST_FULL_SCALE;
      cfg_q.swing_fs   <= vblm_pkg::RST_SWING_FS;
      cfg_q.use_band   <= vblm_pkg::RST_USE_BAND;
      cfg_q.hp_coef    <= vblm_pkg::RST_HP_COEF;
      cfg_q.lp_coef    <= vblm_pkg::RST_LP_COEF;
      cfg_q.pitch_coef <= vblm_pkg::RST_PITCH_COEF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vblm_pkg::CFG_FULL_SCALE: cfg_q.full_scale <= cfg_data_i[vblm_pkg::LVL_W-1:0];
        vblm_pkg::CFG_SWING_FS:   cfg_q.swing_fs   <= cfg_data_i[vblm_pkg::SW_W-1:0];
        vblm_pkg::CFG_USE_BAND:   cfg_q.use_band   <= cfg_data_i[0];
        vblm_pkg::CFG_HP_COEF:    cfg_q.hp_coef    <= cfg_data_i;
        vblm_pkg::CFG_LP_COEF:    cfg_q.lp_coef    <= cfg_data_i;
        vblm_pkg::CFG_PITCH_COEF: cfg_q.pitch_coef <= cfg_data_i;
        default:                  cfg_q            <= cfg_q;
      endcase
    end
  end

  vblm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  vblm_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (sample_i),
    .window_end_i   (window_end_i),
    .kind_o         (kind_o),
    .pitch_sample_o (pitch_sample_o),
    .level_o        (level_o),
    .average_o      (average_o),
    .bias_o         (bias_o),
    .swing_o        (swing_o),
    .raw_swing_o    (raw_swing_o),
    .window_count_o (window_count_o),
    .last_o         (last_o)
  );

  `VBLM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `VBLM_ASSERT_NOW(a_summary_is_last, out_valid_o && kind_o, last_o)
  `VBLM_ASSERT_NOW(a_pitch_word_clean, out_valid_o && !kind_o, level_o == '0 && swing_o == '0)
  `VBLM_ASSERT_NOW(a_level_clamped, out_valid_o && kind_o, level_o <= cfg_q.full_scale)

endmodule

[sv/vblm_div.sv]
// ----------------------------------------------------------------------------
// vblm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vblm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vblm_pkg::NUM_W-1:0]    dividend_i,
  input  logic [vblm_pkg::SW_W-1:0]     divisor_i,
  output logic [vblm_pkg::NUM_W-1:0]    quotient_o,
  output logic                          done_o
);

  localparam int CW = $clog2(vblm_pkg::NUM_W);

  logic                          busy_q;
  logic                          done_q;
  logic [CW-1:0]                 cnt_q;
  logic [vblm_pkg::NUM_W-1:0]    quo_q;
  logic [vblm_pkg::SW_W-1:0]     rem_q;
  logic [vblm_pkg::SW_W:0]       shifted;
  logic [vblm_pkg::SW_W+1:0]     trial;

  assign shifted = {rem_q, quo_q[vblm_pkg::NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (!trial[vblm_pkg::SW_W+1]) begin
        rem_q <= trial[vblm_pkg::SW_W-1:0];
        quo_q <= {quo_q[vblm_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[vblm_pkg::SW_W-1:0];
        quo_q <= {quo_q[vblm_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(vblm_pkg::NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[sv/vblm_datapath.sv]
// ----------------------------------------------------------------------------
// vblm_datapath
// filter state, shared multiplier, window trackers and result register
// ----------------------------------------------------------------------------
module vblm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vblm_pkg::cfg_t                      cfg_i,
  input  vblm_pkg::cmd_t                      cmd_i,
  output vblm_pkg::sts_t                      sts_o,
  input  logic [vblm_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic                                window_end_i,
  output logic                                kind_o,
  output logic signed [vblm_pkg::PITCH_W-1:0] pitch_sample_o,
  output logic [vblm_pkg::LVL_W-1:0]          level_o,
  output logic [vblm_pkg::LVL_W-1:0]          average_o,
  output logic [vblm_pkg::SW_W-1:0]           bias_o,
  output logic [vblm_pkg::SW_W-1:0]           swing_o,
  output logic [vblm_pkg::SW_W-1:0]           raw_swing_o,
  output logic [vblm_pkg::CNT_W-1:0]          window_count_o,
  output logic                                last_o
);

  localparam int OW  = vblm_pkg::OPA_W;
  localparam int PW  = vblm_pkg::PROD_W;
  localparam int SW  = vblm_pkg::SUM_W;
  localparam int FB  = vblm_pkg::FRAC_BITS;
  localparam int SB  = vblm_pkg::SAT_BITS;
  localparam int RW  = vblm_pkg::SAMPLE_BITS + 1;
  localparam int PSW = vblm_pkg::PSUM_W;
  localparam int NW  = vblm_pkg::NUM_W;
  localparam int LW  = vblm_pkg::LVL_W;
  localparam int BW  = vblm_pkg::SW_W + 3;

  localparam logic signed [PW-1:0]  ROUND_HALF = PW'(16384);
  localparam logic signed [PSW-1:0] P_HI = PSW'(32767);
  localparam logic signed [PSW-1:0] P_LO = -PSW'(32768);
  localparam logic signed [PSW-1:0] P_BIAS = PSW'((1 << vblm_pkg::PITCH_SH) - 1);

  // item latch
  logic [vblm_pkg::SAMPLE_BITS-1:0] x_q;
  logic                             wend_q;
  logic                             warm_q;

  // filter state
  vblm_pkg::fix_t hp1_prev_q, hp1_out_q, hp2_prev_q, hp2_out_q, band_q;
  vblm_pkg::fix_t ps1_q, ps2_q;
  logic signed [PSW-1:0]              psum_q;
  logic [vblm_pkg::PHASE_W-1:0]       phase_q;
  logic signed [vblm_pkg::PITCH_W-1:0] pitch_val_q;

  // window trackers
  logic [RW-1:0]                raw_min_q, raw_max_q;
  vblm_pkg::fix_t               band_min_q, band_max_q;
  logic                         seeded_q;
  logic [vblm_pkg::CNT_W-1:0]   cnt_q;
  logic [vblm_pkg::SW_W-1:0]    base_q;
  logic                         base_valid_q;
  logic [vblm_pkg::ACC_W-1:0]   acc_q;
  logic                         acc_valid_q;
  logic [NW-1:0]                num_q;

  // multiplier path
  vblm_pkg::fix_t                   x_fix;
  logic signed [OW-1:0]             opa;
  logic [vblm_pkg::COEF_W-1:0]      coef;
  vblm_pkg::fix_t                   base_sel;
  logic signed [PW-1:0]             prod_d, prod_q, rnd_full;
  logic signed [SW-1:0]             wb_sum;
  vblm_pkg::fix_t                   wb_val;

  // pitch decimation
  logic signed [PSW-1:0]            psum_new, psum_adj, pdiv;
  logic [vblm_pkg::PHASE_W-1:0]     phase_new;
  logic                             fire;
  logic signed [vblm_pkg::PITCH_W-1:0] pitch_sat;

  // window summary
  logic [RW-1:0]                    raw_sw13;
  logic [vblm_pkg::SW_W-1:0]        raw_sw, band_sw, sw;
  logic [SB:0]                      bdiff, bsh;
  logic [NW-1:0]                    quo;
  logic                             div_done;
  logic [LW-1:0]                    level;
  logic [vblm_pkg::ACC_W:0]         acc_sum;
  logic [vblm_pkg::ACC_W-1:0]       acc_d;
  logic [RW-1:0]                    mid;
  logic signed [BW-1:0]             bdelta, bnew;
  logic [vblm_pkg::SW_W-1:0]        base_d;

  assign x_fix = {{(SB-vblm_pkg::SAMPLE_BITS-FB){1'b0}}, x_q, {FB{1'b0}}};

  always_comb begin
    opa      = '0;
    coef     = cfg_i.hp_coef;
    base_sel = '0;
    case (cmd_i.op)
      vblm_pkg::OP_HP1: begin
        opa = OW'(hp1_out_q) + OW'(x_fix) - OW'(hp1_prev_q);
      end
      vblm_pkg::OP_PS1: begin
        opa      = OW'(hp1_out_q) - OW'(ps1_q);
        coef     = cfg_i.pitch_coef;
        base_sel = ps1_q;
      end
      vblm_pkg::OP_PS2: begin
        opa      = OW'(ps1_q) - OW'(ps2_q);
        coef     = cfg_i.pitch_coef;
        base_sel = ps2_q;
      end
      vblm_pkg::OP_HP2: begin
        opa = OW'(hp2_out_q) + OW'(hp1_out_q) - OW'(hp2_prev_q);
      end
      vblm_pkg::OP_BAND: begin
        opa      = OW'(hp2_out_q) - OW'(band_q);
        coef     = cfg_i.lp_coef;
        base_sel = band_q;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign prod_d   = PW'(opa) * PW'($signed({1'b0, coef}));
  // round to nearest, ties up
  assign rnd_full = (prod_q + ROUND_HALF) >>> vblm_pkg::COEF_W;
  assign wb_sum   = SW'(rnd_full) + SW'(base_sel);
  assign wb_val   = vblm_pkg::sat_fix(wb_sum);

  assign psum_new  = psum_q + PSW'(wb_val);
  assign phase_new = phase_q + 1'b1;
  assign fire      = phase_new >= vblm_pkg::PHASE_W'(vblm_pkg::DECIMATE);
  // truncate toward zero
  assign psum_adj  = psum_new + (psum_new[PSW-1] ? P_BIAS : '0);
  assign pdiv      = psum_adj >>> vblm_pkg::PITCH_SH;
  always_comb begin
    if (pdiv > P_HI) pitch_sat = P_HI[vblm_pkg::PITCH_W-1:0];
    else if (pdiv < P_LO) pitch_sat = P_LO[vblm_pkg::PITCH_W-1:0];
    else pitch_sat = pdiv[vblm_pkg::PITCH_W-1:0];
  end

  // swings
  assign raw_sw13 = raw_max_q - raw_min_q;
  assign raw_sw   = (raw_sw13 > RW'(vblm_pkg::SW_MAX)) ? vblm_pkg::SW_MAX
                                                     : raw_sw13[vblm_pkg::SW_W-1:0];
  assign bdiff    = (SB+1)'(band_max_q) - (SB+1)'(band_min_q);
  assign bsh      = bdiff >> FB;
  assign band_sw  = (bsh > (SB+1)'(vblm_pkg::SW_MAX)) ? vblm_pkg::SW_MAX
                                                    : bsh[vblm_pkg::SW_W-1:0];
  assign sw       = (cfg_i.use_band && seeded_q) ? band_sw : raw_sw;

  vblm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (cfg_i.swing_fs),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_comb begin
    if (cfg_i.swing_fs == '0) level = cfg_i.full_scale;
    else if (quo > NW'(cfg_i.full_scale)) level = cfg_i.full_scale;
    else level = quo[LW-1:0];
  end

  assign acc_sum = ({1'b0, acc_q} + (vblm_pkg::ACC_W+1)'(level))
                 - (vblm_pkg::ACC_W+1)'(acc_q >> vblm_pkg::MEAN_SHIFT);
  assign acc_d   = acc_valid_q ? acc_sum[vblm_pkg::ACC_W-1:0]
                               : vblm_pkg::ACC_W'(level) << vblm_pkg::MEAN_SHIFT;

  // baseline moves an arithmetic-shifted fraction of the gap to the midpoint
  assign mid    = RW'(({1'b0, raw_max_q} + {1'b0, raw_min_q}) >> 1);
  assign bdelta = $signed(BW'(mid)) - $signed(BW'(base_q));
  assign bnew   = $signed(BW'(base_q)) + (bdelta >>> vblm_pkg::BIAS_SHIFT);
  always_comb begin
    if (!base_valid_q) begin
      base_d = (mid > RW'(vblm_pkg::SW_MAX)) ? vblm_pkg::SW_MAX
                                            : mid[vblm_pkg::SW_W-1:0];
    end else if (bnew < 0) begin
      base_d = '0;
    end else if (bnew > $signed(BW'(vblm_pkg::SW_MAX))) begin
      base_d = vblm_pkg::SW_MAX;
    end else begin
      base_d = bnew[vblm_pkg::SW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q          <= '0;
      wend_q       <= 1'b0;
      warm_q       <= 1'b0;
      hp1_prev_q   <= '0;
      hp1_out_q    <= '0;
      hp2_prev_q   <= '0;
      hp2_out_q    <= '0;
      band_q       <= '0;
      ps1_q        <= '0;
      ps2_q        <= '0;
      psum_q       <= '0;
      phase_q      <= '0;
      pitch_val_q  <= '0;
      raw_min_q    <= '1;
      raw_max_q    <= '0;
      band_min_q   <= '0;
      band_max_q   <= '0;
      seeded_q     <= 1'b0;
      cnt_q        <= '0;
      base_q       <= '0;
      base_valid_q <= 1'b0;
      acc_q        <= '0;
      acc_valid_q  <= 1'b0;
      num_q        <= '0;
      prod_q       <= '0;
    end else begin
      if (cmd_i.accept) begin
        x_q    <= sample_i;
        wend_q <= window_end_i;
        warm_q <= cnt_q >= vblm_pkg::CNT_W'(vblm_pkg::WARMUP);
        if ({1'b0, sample_i} < raw_min_q) raw_min_q <= {1'b0, sample_i};
        if ({1'b0, sample_i} > raw_max_q) raw_max_q <= {1'b0, sample_i};
      end
      if (cmd_i.mul_en) prod_q <= prod_d;
      if (cmd_i.wb_en) begin
        case (cmd_i.op)
          vblm_pkg::OP_HP1: begin
            hp1_out_q  <= wb_val;
            hp1_prev_q <= x_fix;
          end
          vblm_pkg::OP_PS1: begin
            ps1_q <= wb_val;
          end
          vblm_pkg::OP_PS2: begin
            ps2_q <= wb_val;
            if (fire) begin
              psum_q      <= '0;
              phase_q     <= '0;
              pitch_val_q <= pitch_sat;
            end else begin
              psum_q  <= psum_new;
              phase_q <= phase_new;
            end
          end
          vblm_pkg::OP_HP2: begin
            hp2_out_q  <= wb_val;
            hp2_prev_q <= hp1_out_q;
          end
          vblm_pkg::OP_BAND: begin
            band_q <= wb_val;
            if (warm_q) begin
              if (!seeded_q) begin
                band_min_q <= wb_val;
                band_max_q <= wb_val;
                seeded_q   <= 1'b1;
              end else if (wb_val < band_min_q) begin
                band_min_q <= wb_val;
              end else if (wb_val > band_max_q) begin
                band_max_q <= wb_val;
              end
            end
            if (cnt_q != vblm_pkg::CNT_MAX) cnt_q <= cnt_q + 1'b1;
          end
          default: begin
            band_q <= band_q;
          end
        endcase
      end
      if (cmd_i.lvl_mul) num_q <= NW'(sw) * NW'(cfg_i.full_scale);
      if (cmd_i.ld_win) begin
        base_q       <= base_d;
        base_valid_q <= 1'b1;
        acc_q        <= acc_d;
        acc_valid_q  <= 1'b1;
        // window restart
        psum_q     <= '0;
        phase_q    <= '0;
        raw_min_q  <= '1;
        raw_max_q  <= '0;
        band_min_q <= '0;
        band_max_q <= '0;
        seeded_q   <= 1'b0;
        cnt_q      <= '0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_pitch) begin
      kind_o         <= 1'b0;
      pitch_sample_o <= pitch_val_q;
      level_o        <= '0;
      average_o      <= '0;
      bias_o         <= '0;
      swing_o        <= '0;
      raw_swing_o    <= '0;
      window_count_o <= '0;
      last_o         <= !wend_q;
    end else if (cmd_i.ld_win) begin
      kind_o         <= 1'b1;
      pitch_sample_o <= '0;
      level_o        <= level;
      average_o      <= LW'(acc_d >> vblm_pkg::MEAN_SHIFT);
      bias_o         <= base_d;
      swing_o        <= sw;
      raw_swing_o    <= raw_sw;
      window_count_o <= cnt_q;
      last_o         <= 1'b1;
    end
  end

  assign sts_o.pitch_emit = fire && warm_q;
  assign sts_o.wend       = wend_q;
  assign sts_o.div_done   = div_done;

endmodule

[sv/vblm_ctrl.sv]
// ----------------------------------------------------------------------------
// vblm_ctrl
// sequencer for the filter chain, result hand-off and window summary
// ----------------------------------------------------------------------------
module vblm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output vblm_pkg::cmd_t cmd_o,
  input  vblm_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_EMIT_P,
    ST_LVL_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_W
  } state_e;

  state_e            state_q;
  vblm_pkg::mul_op_e op_q;
  logic              out_valid_q;
  logic              out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o    = '0;
    cmd_o.op = op_q;
    case (state_q)
      ST_IDLE:      cmd_o.accept    = in_valid_i;
      ST_MUL:       cmd_o.mul_en    = 1'b1;
      ST_WB:        cmd_o.wb_en     = 1'b1;
      ST_EMIT_P:    cmd_o.ld_pitch  = out_free;
      ST_LVL_MUL:   cmd_o.lvl_mul   = 1'b1;
      ST_DIV_START: cmd_o.div_start = 1'b1;
      ST_EMIT_W:    cmd_o.ld_win    = out_free;
      default:      cmd_o.accept    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= vblm_pkg::OP_HP1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.ld_pitch || cmd_o.ld_win) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MUL;
            op_q    <= vblm_pkg::OP_HP1;
          end
        end
        ST_MUL: begin
          state_q <= ST_WB;
        end
        ST_WB: begin
          case (op_q)
            vblm_pkg::OP_HP1: begin
              op_q    <= vblm_pkg::OP_PS1;
              state_q <= ST_MUL;
            end
            vblm_pkg::OP_PS1: begin
              op_q    <= vblm_pkg::OP_PS2;
              state_q <= ST_MUL;
            end
            vblm_pkg::OP_PS2: begin
              op_q    <= vblm_pkg::OP_HP2;
              state_q <= sts_i.pitch_emit ? ST_EMIT_P : ST_MUL;
            end
            vblm_pkg::OP_HP2: begin
              op_q    <= vblm_pkg::OP_BAND;
              state_q <= ST_MUL;
            end
            default: begin
              state_q <= sts_i.wend ? ST_LVL_MUL : ST_IDLE;
            end
          endcase
        end
        ST_EMIT_P: begin
          if (out_free) state_q <= ST_MUL;
        end
        ST_LVL_MUL: begin
          state_q <= ST_DIV_START;
        end
        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (sts_i.div_done) state_q <= ST_EMIT_W;
        end
        ST_EMIT_W: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

[bench/tb_voice_band_level_meter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice band level meter testbench
// drives sample words with random gaps and output stalls, predicts every pitch
// word and window summary with a cycle-free model of the filters and window
// math, and compares each accepted output word field by field
// ----------------------------------------------------------------------------
module tb_voice_band_level_meter;

  localparam int LIMIT = 600000;
  localparam int SETTLE = 48;
  localparam int RANDOM_WORDS = 750;
  localparam logic [vblm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam longint FIX_HI = (longint'(1) <<< (vblm_pkg::SAT_BITS - 1)) - 1;
  localparam longint FIX_LO = -FIX_HI - 1;

  typedef struct {
    logic                                kind;
    logic signed [vblm_pkg::PITCH_W-1:0] pitch;
    logic [vblm_pkg::LVL_W-1:0]          level;
    logic [vblm_pkg::LVL_W-1:0]          average;
    logic [vblm_pkg::SW_W-1:0]           bias;
    logic [vblm_pkg::SW_W-1:0]           swing;
    logic [vblm_pkg::SW_W-1:0]           raw_swing;
    logic [vblm_pkg::CNT_W-1:0]          count;
    logic                                last;
  } meter_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [vblm_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic window_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic signed [vblm_pkg::PITCH_W-1:0] pitch_sample;
  logic [vblm_pkg::LVL_W-1:0] level, average;
  logic [vblm_pkg::SW_W-1:0] bias, swing, raw_swing;
  logic [vblm_pkg::CNT_W-1:0] window_count;
  logic last;
  logic cfg_we = 1'b0;
  logic [vblm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vblm_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  voice_band_level_meter dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .sample_i(sample), .window_end_i(window_end),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .pitch_sample_o(pitch_sample), .level_o(level),
    .average_o(average), .bias_o(bias), .swing_o(swing),
    .raw_swing_o(raw_swing), .window_count_o(window_count), .last_o(last),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor configuration and state
  int unsigned fs_q, sfs_q, band_sel_q, hp_c_q, lp_c_q, pt_c_q;
  longint hpa_last_x, hpa_y, hpb_last_x, hpb_y, band_y, pt1_y, pt2_y, pt_acc;
  int unsigned pt_phase, lo_raw, hi_raw, win_count, bias_reg, avg_acc;
  longint lo_band, hi_band;
  bit band_started, bias_ok, avg_ok;

  meter_word_t pending_words[$];
  int errors = 0;
  int windows_seen = 0;
  int pitches_seen = 0;
  int words_sent = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic longint clamp_fix(input longint v);
    if (v > FIX_HI) return FIX_HI;
    if (v < FIX_LO) return FIX_LO;
    return v;
  endfunction

  // q1.15 product, rounded to nearest with ties upward
  function automatic longint scale_q15(input longint a, input int unsigned c);
    longint p;
    p = a * longint'(c) + 16384;
    if (p >= 0) return p / 32768;
    return -((-p + 32767) / 32768);
  endfunction

  task automatic restart_window();
    pt_acc = 0; pt_phase = 0;
    lo_raw = 'h1FFF; hi_raw = 0;
    lo_band = 0; hi_band = 0; band_started = 0;
    win_count = 0;
  endtask

  task automatic reset_meter_model();
    fs_q = vblm_pkg::RST_FULL_SCALE; sfs_q = vblm_pkg::RST_SWING_FS;
    band_sel_q = vblm_pkg::RST_USE_BAND;
    hp_c_q = vblm_pkg::RST_HP_COEF; lp_c_q = vblm_pkg::RST_LP_COEF;
    pt_c_q = vblm_pkg::RST_PITCH_COEF;
    hpa_last_x = 0; hpa_y = 0; hpb_last_x = 0; hpb_y = 0; band_y = 0;
    pt1_y = 0; pt2_y = 0;
    bias_reg = 0; bias_ok = 0; avg_acc = 0; avg_ok = 0;
    restart_window();
  endtask

  task automatic predict_meter(input logic [vblm_pkg::SAMPLE_BITS-1:0] s, input logic wend);
    longint x, h1, h2, v, d, b;
    bit warm;
    int unsigned rsw, bsw, sw, mid, lvl;
    meter_word_t w;
    warm = win_count >= vblm_pkg::WARMUP;
    x = longint'(s) <<< vblm_pkg::FRAC_BITS;
    if (s < lo_raw) lo_raw = s;
    if (s > hi_raw) hi_raw = s;
    h1 = clamp_fix(scale_q15(hpa_y + x - hpa_last_x, hp_c_q));
    hpa_last_x = x; hpa_y = h1;
    pt1_y = clamp_fix(pt1_y + scale_q15(h1 - pt1_y, pt_c_q));
    pt2_y = clamp_fix(pt2_y + scale_q15(pt1_y - pt2_y, pt_c_q));
    pt_acc += pt2_y;
    pt_phase++;
    if (pt_phase >= vblm_pkg::DECIMATE) begin
      if (warm) begin
        v = pt_acc / (longint'(vblm_pkg::DECIMATE) <<< vblm_pkg::FRAC_BITS);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        w = '{default: '0};
        w.pitch = v[vblm_pkg::PITCH_W-1:0];
        w.last = !wend;
        pending_words.push_back(w);
      end
      pt_acc = 0; pt_phase = 0;
    end
    h2 = clamp_fix(scale_q15(hpb_y + h1 - hpb_last_x, hp_c_q));
    hpb_last_x = h1; hpb_y = h2;
    band_y = clamp_fix(band_y + scale_q15(h2 - band_y, lp_c_q));
    if (warm) begin
      if (!band_started) begin
        lo_band = band_y; hi_band = band_y; band_started = 1;
      end else if (band_y < lo_band) begin
        lo_band = band_y;
      end else if (band_y > hi_band) begin
        hi_band = band_y;
      end
    end
    if (win_count < 65535) win_count++;
    if (wend) begin
      rsw = hi_raw - lo_raw;
      if (rsw > 4095) rsw = 4095;
      if (band_started) begin
        d = (hi_band - lo_band) >>> vblm_pkg::FRAC_BITS;
        bsw = (d > 4095) ? 4095 : int'(d);
      end else begin
        bsw = rsw;  // starved window falls back to raw swing
      end
      sw = band_sel_q ? bsw : rsw;
      mid = (hi_raw + lo_raw) / 2;
      if (!bias_ok) begin
        bias_reg = (mid > 4095) ? 4095 : mid;
        bias_ok = 1;
      end else begin
        b = longint'(bias_reg)
          + ((longint'(mid) - longint'(bias_reg)) >>> vblm_pkg::BIAS_SHIFT);
        if (b < 0) b = 0;
        if (b > 4095) b = 4095;
        bias_reg = int'(b);
      end
      if (sfs_q == 0) begin
        lvl = fs_q;
      end else begin
        lvl = (sw * fs_q) / sfs_q;
        if (lvl > fs_q) lvl = fs_q;
      end
      if (!avg_ok) begin
        avg_acc = lvl << vblm_pkg::MEAN_SHIFT;
        avg_ok = 1;
      end else begin
        avg_acc = (avg_acc + lvl - (avg_acc >> vblm_pkg::MEAN_SHIFT)) & 'hFFFF;
      end
      w = '{default: '0};
      w.kind = 1'b1;
      w.level = lvl[vblm_pkg::LVL_W-1:0];
      w.average = avg_acc[vblm_pkg::MEAN_SHIFT +: vblm_pkg::LVL_W];
      w.bias = bias_reg[vblm_pkg::SW_W-1:0];
      w.swing = sw[vblm_pkg::SW_W-1:0];
      w.raw_swing = rsw[vblm_pkg::SW_W-1:0];
      w.count = win_count[vblm_pkg::CNT_W-1:0];
      w.last = 1'b1;
      pending_words.push_back(w);
      restart_window();
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 30)
      $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // output checker
  always @(posedge clk_i) begin
    meter_word_t w;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", kind, -1);
      end else begin
        w = pending_words.pop_front();
        if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
        if (pitch_sample !== w.pitch) report_mismatch("pitch_sample", pitch_sample, w.pitch);
        if (level !== w.level) report_mismatch("level", level, w.level);
        if (average !== w.average) report_mismatch("average", average, w.average);
        if (bias !== w.bias) report_mismatch("bias", bias, w.bias);
        if (swing !== w.swing) report_mismatch("swing", swing, w.swing);
        if (raw_swing !== w.raw_swing) report_mismatch("raw_swing", raw_swing, w.raw_swing);
        if (window_count !== w.count) report_mismatch("window_count", window_count, w.count);
        if (last !== w.last) report_mismatch("last", last, w.last);
        if (w.kind) windows_seen++;
        else pitches_seen++;
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_sample(input logic [vblm_pkg::SAMPLE_BITS-1:0] s, input logic wend);
    in_valid <= 1'b1;
    sample <= s;
    window_end <= wend;
    do @(posedge clk_i); while (in_stall);
    predict_meter(s, wend);
    words_sent++;
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain_meter();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [vblm_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[vblm_pkg::CFG_DAT_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      vblm_pkg::CFG_FULL_SCALE: fs_q = val & 'h3FF;
      vblm_pkg::CFG_SWING_FS:   sfs_q = val & 'hFFF;
      vblm_pkg::CFG_USE_BAND:   band_sel_q = val & 1;
      vblm_pkg::CFG_HP_COEF:    hp_c_q = val & 'h7FFF;
      vblm_pkg::CFG_LP_COEF:    lp_c_q = val & 'h7FFF;
      vblm_pkg::CFG_PITCH_COEF: pt_c_q = val & 'h7FFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_all(input int unsigned f, input int unsigned sf, input int unsigned u,
                         input int unsigned hp, input int unsigned lp, input int unsigned pc);
    write_reg(vblm_pkg::CFG_FULL_SCALE, f);
    write_reg(vblm_pkg::CFG_SWING_FS, sf);
    write_reg(vblm_pkg::CFG_USE_BAND, u);
    write_reg(vblm_pkg::CFG_HP_COEF, hp);
    write_reg(vblm_pkg::CFG_LP_COEF, lp);
    write_reg(vblm_pkg::CFG_PITCH_COEF, pc);
  endtask

  // rail samples, single-sample windows, starved windows at reset settings
  task automatic test_rail_samples();
    send_sample('0, 1'b1);
    send_sample('1, 1'b1);
    send_sample(12'h555, 1'b0);
    send_sample(12'hAAA, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    drain_meter();
  endtask

  // register extremes, zero divisor and an ignored index, short windows each
  task automatic test_register_extremes();
    set_all(1023, 1, 0, 32767, 32767, 32767);
    send_sample('1, 1'b0);
    send_sample('0, 1'b1);
    drain_meter();
    set_all(0, 4095, 1, 0, 0, 0);
    send_sample(12'h800, 1'b0);
    send_sample(12'h7FF, 1'b1);
    drain_meter();
    set_all(1023, 0, 0, 16384, 1, 1);  // zero divisor reports full scale
    write_reg(CFG_SPARE, 'h7FFF);
    send_sample(12'h123, 1'b0);
    send_sample(12'hEDC, 1'b1);
    drain_meter();
    set_all(vblm_pkg::RST_FULL_SCALE, vblm_pkg::RST_SWING_FS, vblm_pkg::RST_USE_BAND,
            vblm_pkg::RST_HP_COEF, vblm_pkg::RST_LP_COEF, vblm_pkg::RST_PITCH_COEF);
  endtask

  task automatic send_window(input int len);
    int center, amp, period, t, fold, v;
    center = $urandom_range(300, 3800);
    amp = ($urandom_range(9) == 0) ? 2100 : $urandom_range(0, 1500);
    period = $urandom_range(4, 40);
    for (int i = 0; i < len; i++) begin
      t = i % period;
      fold = (t < period / 2) ? t : period - t;
      v = center + (amp * (4 * fold - period)) / period + $urandom_range(0, 128) - 64;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_sample(v[vblm_pkg::SAMPLE_BITS-1:0], i == len - 1);
    end
  endtask

  // long windows past warm-up with shaped content, plus short noisy windows
  task automatic test_random_windows();
    int start, n, len;
    start = words_sent;
    n = 0;
    while (words_sent - start < RANDOM_WORDS) begin
      quiet = (words_sent - start > 250) && (words_sent - start < 420);
      if (n % 3 == 2) begin
        drain_meter();
        set_all($urandom_range(1, 1023), ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4095),
                $urandom_range(1), $urandom_range(20000, 32767), $urandom_range(0, 32767),
                $urandom_range(0, 32767));
      end
      if ($urandom_range(99) < 75) begin
        send_window($urandom_range(vblm_pkg::WARMUP + 1, vblm_pkg::WARMUP + 100));
      end else begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++)
          send_sample(vblm_pkg::SAMPLE_BITS'($urandom_range(0, 4095)),
                      (i == len - 1) || ($urandom_range(49) == 0));
      end
      n++;
    end
    quiet = 1'b0;
    drain_meter();
  endtask

  initial begin
    reset_meter_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rail_samples();
    test_register_extremes();
    test_random_windows();
    $display("sent %0d samples; checked %0d window summaries and %0d pitch words",
             words_sent, windows_seen, pitches_seen);
    $display("config covered register extremes, zero divisor and raw/band selection");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
